### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SWKR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SWKR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/swkr_pkg.sv
// Shared types and constants of the single-wire key-state receiver.
// No dependencies; used by every RTL module of the block.
package swkr_pkg;

    localparam int STATE_BYTES_DEFAULT = 16;
    localparam int PERIOD_W            = 16;
    localparam int TICK_W              = 17;
    localparam int BYTE_INDEX_W        = 4;
    localparam int QUEUE_DEPTH         = 4;
    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd50;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LENGTH,
        MODE_DATA
    } mode_t;

    // One finished byte handed from the front end to the back end.
    typedef struct packed {
        logic                    too_long;
        logic [BYTE_INDEX_W-1:0] index;
        logic [7:0]              data;
    } rec_t;

    // Queue status seen by its two sides.
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

### rtl/swkr_front.sv
// Front end: bit timing, deserializing and frame bookkeeping.
// Depends on swkr_pkg; pushes one record per finished byte that needs work.
module swkr_front #(
    parameter int STATE_BYTES = swkr_pkg::STATE_BYTES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           sample_valid,
    input  logic                           line_level,
    input  logic                           cfg_we,
    input  logic [swkr_pkg::PERIOD_W-1:0]  cfg_wdata,
    output logic                           push,
    output swkr_pkg::rec_t                 push_rec
);

    swkr_pkg::mode_t mode_reg, mode_next;
    logic [swkr_pkg::PERIOD_W-1:0]     period_reg;
    logic [swkr_pkg::TICK_W-1:0]       tick_reg, tick_next;
    logic [2:0]                        bit_cnt_reg, bit_cnt_next;
    logic [7:0]                        shift_reg, shift_next;
    logic [swkr_pkg::BYTE_INDEX_W-1:0] index_reg, index_next;
    logic [swkr_pkg::BYTE_INDEX_W-1:0] flen_reg, flen_next;
    logic                              prev_reg;

    logic [swkr_pkg::PERIOD_W-1:0] eff_period;
    logic                          start_edge;
    logic                          sample_now;
    logic                          byte_done;
    logic [7:0]                    full_byte;
    logic                          too_long;
    logic                          frame_end;

    assign eff_period = (period_reg == '0) ? swkr_pkg::PERIOD_W'(1) : period_reg;
    assign start_edge = sample_valid && prev_reg && !line_level;
    assign sample_now = sample_valid && (mode_reg != swkr_pkg::MODE_IDLE)
                        && (tick_reg == swkr_pkg::TICK_W'(1));
    assign byte_done  = sample_now && (bit_cnt_reg == 3'd7);
    assign full_byte  = shift_reg | (8'(line_level) << bit_cnt_reg);
    assign too_long   = full_byte >= 8'(STATE_BYTES);
    assign frame_end  = ({1'b0, index_reg} + 5'd1) >= {1'b0, flen_reg};

    // Next state.
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            swkr_pkg::MODE_IDLE: begin
                if (start_edge) mode_next = swkr_pkg::MODE_LENGTH;
            end
            swkr_pkg::MODE_LENGTH: begin
                if (byte_done) begin
                    if (too_long || full_byte == 8'd0) mode_next = swkr_pkg::MODE_IDLE;
                    else mode_next = swkr_pkg::MODE_DATA;
                end
            end
            swkr_pkg::MODE_DATA: begin
                if (byte_done && frame_end) mode_next = swkr_pkg::MODE_IDLE;
            end
            default: mode_next = swkr_pkg::MODE_IDLE;
        endcase
    end

    // Record output toward the queue.
    always_comb begin
        push              = 1'b0;
        push_rec.too_long = 1'b0;
        push_rec.index    = index_reg;
        push_rec.data     = full_byte;
        unique case (mode_reg)
            swkr_pkg::MODE_LENGTH: begin
                push              = byte_done && too_long;
                push_rec.too_long = 1'b1;
            end
            swkr_pkg::MODE_DATA: push = byte_done;
            default: push = 1'b0;
        endcase
    end

    // Timing and shift datapath.
    always_comb begin
        tick_next    = tick_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        index_next   = index_reg;
        flen_next    = flen_reg;
        if (mode_reg == swkr_pkg::MODE_IDLE) begin
            if (start_edge) begin
                tick_next    = swkr_pkg::TICK_W'(eff_period)
                               + swkr_pkg::TICK_W'(eff_period >> 1);
                bit_cnt_next = 3'd0;
                shift_next   = 8'd0;
                index_next   = '0;
            end
        end else if (sample_valid) begin
            tick_next = tick_reg - swkr_pkg::TICK_W'(1);
            if (sample_now) begin
                tick_next = swkr_pkg::TICK_W'(eff_period);
                if (byte_done) begin
                    bit_cnt_next = 3'd0;
                    shift_next   = 8'd0;
                    if (mode_reg == swkr_pkg::MODE_LENGTH) begin
                        flen_next  = full_byte[swkr_pkg::BYTE_INDEX_W-1:0];
                        index_next = '0;
                    end else begin
                        index_next = index_reg + 1'b1;
                    end
                end else begin
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    shift_next   = full_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= swkr_pkg::MODE_IDLE;
            period_reg  <= swkr_pkg::BIT_PERIOD_RESET;
            prev_reg    <= 1'b1;
            tick_reg    <= '0;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            index_reg   <= '0;
            flen_reg    <= '0;
        end else begin
            mode_reg    <= mode_next;
            tick_reg    <= tick_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            index_reg   <= index_next;
            flen_reg    <= flen_next;
            if (sample_valid) prev_reg <= line_level;
            if (cfg_we) period_reg <= cfg_wdata;
        end
    end

endmodule

### rtl/swkr_fifo.sv
// Short queue of byte records between the front end and the back end.
// Depends on swkr_pkg for the record and status types.
module swkr_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  swkr_pkg::rec_t          push_rec,
    input  logic                    pop,
    output swkr_pkg::rec_t          pop_rec,
    output swkr_pkg::queue_status_t status
);

    localparam int PTR_W = (swkr_pkg::QUEUE_DEPTH > 1) ? $clog2(swkr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(swkr_pkg::QUEUE_DEPTH + 1);

    swkr_pkg::rec_t   entry_reg [swkr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = count_reg == CNT_W'(swkr_pkg::QUEUE_DEPTH);
    assign status.valid = count_reg != '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign pop_rec      = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(swkr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(swkr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### rtl/swkr_back.sv
// Back end: key-state map, change detection, one result per cycle unless stalled.
// Depends on swkr_pkg; pops byte records from swkr_fifo.
module swkr_back #(
    parameter int STATE_BYTES = swkr_pkg::STATE_BYTES_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  swkr_pkg::queue_status_t status,
    input  swkr_pkg::rec_t          pop_rec,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);

    localparam int IDX_W = (STATE_BYTES > 1) ? $clog2(STATE_BYTES) : 1;

    logic [7:0]                        key_state_reg [STATE_BYTES];
    logic                              err_reg, err_next;
    logic [7:0]                        diff_reg, diff_next;
    logic [7:0]                        byte_reg, byte_next;
    logic [swkr_pkg::BYTE_INDEX_W-1:0] index_reg, index_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [7:0]                        m_tdata_reg, m_tdata_next;
    logic                              m_tuser_reg, m_tuser_next;
    logic                              m_tlast_reg, m_tlast_next;

    logic       out_free, busy, emit, last, done_now;
    logic [2:0] low_bit;
    logic [7:0] diff_rest;
    logic [7:0] stored_byte;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign busy      = err_reg || (diff_reg != 8'd0);
    assign emit      = out_free && busy;
    assign diff_rest = diff_reg & (diff_reg - 8'd1);
    assign last      = err_reg || (diff_rest == 8'd0);
    assign done_now  = !busy || (emit && last);
    assign pop       = status.valid && done_now;
    assign stored_byte = key_state_reg[pop_rec.index[IDX_W-1:0]];

    // Lowest changed bit goes out first.
    always_comb begin
        low_bit = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (diff_reg[i]) low_bit = 3'(i);
        end
    end

    always_comb begin
        err_next      = err_reg;
        diff_next     = diff_reg;
        byte_next     = byte_reg;
        index_next    = index_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = err_reg;
            m_tlast_next  = last;
            if (err_reg) begin
                m_tdata_next = 8'd0;
                err_next     = 1'b0;
            end else begin
                m_tdata_next = {byte_reg[low_bit], index_reg, low_bit};
                diff_next    = diff_rest;
            end
        end
        if (pop) begin
            err_next   = pop_rec.too_long;
            diff_next  = pop_rec.too_long ? 8'd0 : (stored_byte ^ pop_rec.data);
            byte_next  = pop_rec.data;
            index_next = pop_rec.index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg      <= 1'b0;
            diff_reg     <= 8'd0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < STATE_BYTES; i++) key_state_reg[i] <= 8'd0;
        end else begin
            err_reg      <= err_next;
            diff_reg     <= diff_next;
            m_tvalid_reg <= m_tvalid_next;
            if (pop && !pop_rec.too_long) begin
                key_state_reg[pop_rec.index[IDX_W-1:0]] <= pop_rec.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        index_reg   <= index_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/single_wire_key_state_receiver_top.sv
// Top level of the single-wire key-state receiver.
// Depends on swkr_pkg, swkr_front, swkr_fifo and swkr_back.

// The block receives a length-framed, LSB-first serial frame from one wire
// sampled once per clock, and reports changes in a map of key states.
// Each accepted input item is one sample of the wire; the wire idles high
// and a falling edge starts a frame. The first bit is sampled 1.5 bit periods
// after the edge and the rest once per period, where the period in samples is
// the value last written on cfg_wdata (50 after reset, 0 treated as 1). The
// first byte is a frame length; a length of STATE_BYTES or more produces a
// single error result (tuser high, tdata zero, tlast high). Every data byte is
// compared with the stored key-state byte at its index, and each changed bit
// produces one result, lowest position first, carrying the key position and
// its new level; tlast marks the final result caused by one sample. The input
// takes one sample per clock for as long as the four-entry byte queue between
// the front end and the back end has room. The back end drains that queue,
// sending one result per clock when the output is not stalled, one for each
// changed bit of a byte. A result passes through the byte queue, the back end's
// change or error register and the output register. Since bytes arrive at most
// every eight samples, input stalls only happen when the output side itself
// stalls for a long time.
module single_wire_key_state_receiver_top #(
    parameter int STATE_BYTES = swkr_pkg::STATE_BYTES_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Wire samples.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] line_level, [7:1] zero
    // Key events.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [6:0] key_position, [7] key_pressed
    output logic                          m_tuser,   // [0] event_kind
    output logic                          m_tlast,   // last_of_run
    // Bit period register.
    input  logic                          cfg_we,
    input  logic [swkr_pkg::PERIOD_W-1:0] cfg_wdata
);

    swkr_pkg::queue_status_t q_status;
    swkr_pkg::rec_t          push_rec;
    swkr_pkg::rec_t          pop_rec;
    logic                    push;
    logic                    pop;
    logic                    sample_valid;

    // A sample is taken whenever the queue can hold the byte it may finish.
    assign s_tready     = !q_status.full;
    assign sample_valid = s_tvalid && s_tready;

    swkr_front #(
        .STATE_BYTES (STATE_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample_valid (sample_valid),
        .line_level   (s_tdata[0]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .push_rec     (push_rec)
    );

    swkr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .status   (q_status)
    );

    swkr_back #(
        .STATE_BYTES (STATE_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (q_status),
        .pop_rec  (pop_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/swkr_checker.sv
// Port-level checks of the key-state receiver, bound to its top level.
// Depends on assert_macros.svh, swkr_pkg and single_wire_key_state_receiver_top.
`include "assert_macros.svh"

module swkr_checker #(
    parameter int STATE_BYTES = swkr_pkg::STATE_BYTES_DEFAULT
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A length error is a run of its own with an all-zero payload.
    `SWKR_ASSERT_NOW(a_error_alone, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'd0), "length error result malformed")

    // Key events only name positions inside the key-state map.
    `SWKR_ASSERT_NOW(a_position_range, m_tvalid && !m_tuser, {1'b0, m_tdata[6:0]} < 8'(STATE_BYTES * 8), "key position beyond the map")

    // Within one run the changed keys come out in ascending position.
    `SWKR_ASSERT_NEXT(a_run_ascending, m_tvalid && m_tready && !m_tlast && !m_tuser, !m_tvalid || (!m_tuser && (m_tdata[6:0] > $past(m_tdata[6:0]))), "run not in ascending order")

    // A stalled result holds.
    `SWKR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

endmodule

bind single_wire_key_state_receiver_top swkr_checker #(
    .STATE_BYTES (STATE_BYTES)
) u_swkr_checker (.*);

### tb/tb.sv
// Self-checking testbench for the single-wire key-state receiver.
// Depends on swkr_pkg and single_wire_key_state_receiver_top; reads no files.
// Wire samples are built into framed byte streams, predicted in place, and checked on the output.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_BYTES   = swkr_pkg::STATE_BYTES_DEFAULT;
    localparam int HOLD_CYCLES = 600;
    localparam int MAX_REPORTS = 40;
    localparam int SETTLE      = 12;
    localparam int ITEM_TARGET = 180;

    typedef struct packed {
        logic       kind;
        logic [6:0] pos;
        logic       pressed;
        logic       last;
    } key_event_t;

    // One directed frame. Byte 0 (the length) sits in the lowest bits of bytes.
    // A frame of zero bytes means a run of idle-high samples only.
    typedef struct packed {
        logic [15:0]  period;
        logic [4:0]   nbytes;
        logic [127:0] bytes;
        logic         tight;
        logic         typed;
        logic         typed_one;
        key_event_t   typed_ev;
    } frame_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_we;
    logic [swkr_pkg::PERIOD_W-1:0] cfg_wdata;

    single_wire_key_state_receiver_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Directed frames. Rows with typed set carry their expectation by hand:
    // key 0 pressed then released after reset, a zero length, and two lengths
    // that are too long. The remaining rows are checked against the predictor.
    frame_row_t directed_frames [8] = '{
        '{16'd1,     5'd2,  128'h0101,                  1'b0, 1'b1, 1'b1,
          '{1'b0, 7'd0, 1'b1, 1'b1}},
        '{16'd1,     5'd2,  128'h0001,                  1'b0, 1'b1, 1'b1,
          '{1'b0, 7'd0, 1'b0, 1'b1}},
        '{16'd1,     5'd1,  128'h00,                    1'b0, 1'b1, 1'b0, '0},
        '{16'd1,     5'd1,  128'h10,                    1'b0, 1'b1, 1'b1,
          '{1'b1, 7'd0, 1'b0, 1'b1}},
        '{16'd1,     5'd1,  128'hFF,                    1'b1, 1'b1, 1'b1,
          '{1'b1, 7'd0, 1'b0, 1'b1}},
        '{16'd1,     5'd2,  128'hA501,                  1'b0, 1'b0, 1'b0, '0},
        '{16'd0,     5'd2,  128'h8001,                  1'b1, 1'b0, 1'b0, '0},
        '{16'd65535, 5'd0,  128'h0,                     1'b0, 1'b0, 1'b0, '0}
    };

    // Predictor state, a mirror of the receiver after every accepted sample.
    swkr_pkg::mode_t               rx_mode;
    logic                          prev_level;
    logic [swkr_pkg::TICK_W-1:0]   tick_cnt;
    logic [2:0]                    bit_cnt;
    logic [7:0]                    shift_reg;
    logic [3:0]                    byte_idx;
    logic [7:0]                    frame_len;
    logic [7:0]                    key_map [KEY_BYTES];
    logic [swkr_pkg::PERIOD_W-1:0] bit_period;

    key_event_t pending_events [$];
    logic       wire_levels [$];
    logic [7:0] frame_bytes [$];
    int         items_sent;
    int         mismatches;
    int         src_gap_max;
    int         snk_gap_max;
    bit         typed_active;
    bit         rx_hold_req;
    bit         last_tight;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Guard against a hang; the slowest correct run is far shorter.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int eff_period();
        return (bit_period == '0) ? 1 : int'(bit_period);
    endfunction

    function automatic key_event_t key_event(logic kind, logic [6:0] pos, logic pressed);
        key_event_t ev;
        ev.kind    = kind;
        ev.pos     = pos;
        ev.pressed = pressed;
        ev.last    = 1'b0;
        return ev;
    endfunction

    // Advances the mirror by one wire sample and queues the key events it causes.
    function automatic void sample_line(input logic lvl);
        logic [7:0] rx_byte;
        logic [7:0] diff;
        key_event_t ev;
        key_event_t run [$];
        if (rx_mode == swkr_pkg::MODE_IDLE) begin
            if (prev_level && !lvl) begin
                rx_mode   = swkr_pkg::MODE_LENGTH;
                tick_cnt  = swkr_pkg::TICK_W'(eff_period() + (eff_period() >> 1));
                bit_cnt   = '0;
                shift_reg = '0;
                byte_idx  = '0;
            end
        end else begin
            tick_cnt = tick_cnt - 1'b1;
            if (tick_cnt == '0) begin
                shift_reg[bit_cnt] = lvl;
                tick_cnt = swkr_pkg::TICK_W'(eff_period());
                if (bit_cnt == 3'd7) begin
                    rx_byte   = shift_reg;
                    bit_cnt   = '0;
                    shift_reg = '0;
                    if (rx_mode == swkr_pkg::MODE_LENGTH) begin
                        frame_len = rx_byte;
                        byte_idx  = '0;
                        if (int'(rx_byte) >= KEY_BYTES) begin
                            run.push_back(key_event(1'b1, 7'd0, 1'b0));
                            rx_mode = swkr_pkg::MODE_IDLE;
                        end else if (rx_byte == 8'd0) begin
                            rx_mode = swkr_pkg::MODE_IDLE;
                        end else begin
                            rx_mode = swkr_pkg::MODE_DATA;
                        end
                    end else begin
                        diff = key_map[byte_idx] ^ rx_byte;
                        for (int j = 0; j < 8; j++) begin
                            if (diff[j]) run.push_back(key_event(1'b0, {byte_idx, 3'(j)}, rx_byte[j]));
                        end
                        key_map[byte_idx] = rx_byte;
                        if (int'(byte_idx) + 1 >= int'(frame_len) || byte_idx == 4'd15) begin
                            rx_mode = swkr_pkg::MODE_IDLE;
                        end
                        byte_idx = byte_idx + 4'd1;
                    end
                end else begin
                    bit_cnt = bit_cnt + 3'd1;
                end
            end
        end
        prev_level = lvl;
        if (run.size() > 0) begin
            ev = run.pop_back();
            ev.last = 1'b1;
            run.push_back(ev);
        end
        if (!typed_active) begin
            foreach (run[i]) pending_events.push_back(run[i]);
        end
    endfunction

    // Offers one sample after a random gap and returns at the edge where it is taken.
    task automatic send_sample(input logic lvl);
        int   gap;
        logic taken;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, lvl};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        items_sent++;
        sample_line(lvl);
    endtask

    // Waits until every predicted event has been seen, then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_events.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic pad_to_idle();
        while (rx_mode != swkr_pkg::MODE_IDLE) send_sample(1'b1);
    endtask

    // The period is only changed with the receiver idle and its output empty.
    task automatic set_period(input logic [swkr_pkg::PERIOD_W-1:0] value);
        pad_to_idle();
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        bit_period  = value;
    endtask

    // Sends frame_bytes as one frame: a start bit, then every byte LSB first
    // with no framing between bytes, then a stop bit. A tight frame ends right
    // after the last sample point, and the next frame starts without idle time.
    // A broken frame is cut short and has one sample flipped.
    task automatic run_frame(input bit tight, input bit broken);
        int eff;
        int cnt;
        int cut;
        int flip;
        eff = eff_period();
        if (!last_tight) begin
            repeat ($urandom_range(1, 4)) send_sample(1'b1);
        end
        wire_levels.delete();
        repeat (eff) wire_levels.push_back(1'b0);
        foreach (frame_bytes[i]) begin
            for (int j = 0; j < 8; j++) begin
                cnt = (tight && i == frame_bytes.size() - 1 && j == 7) ? (eff >> 1) + 1 : eff;
                repeat (cnt) wire_levels.push_back(frame_bytes[i][j]);
            end
        end
        if (!tight) repeat (eff) wire_levels.push_back(1'b1);
        if (broken) begin
            cut = $urandom_range(1, wire_levels.size() - 1);
            while (wire_levels.size() > cut) void'(wire_levels.pop_back());
            flip = $urandom_range(0, wire_levels.size() - 1);
            wire_levels[flip] = ~wire_levels[flip];
        end
        foreach (wire_levels[i]) send_sample(wire_levels[i]);
        last_tight = tight;
    endtask

    // Random frame content: mostly short valid lengths whose bytes keep, flip one
    // bit of, randomize or invert the current key map, sometimes a zero or too-long length.
    task automatic random_frame_bytes();
        int len;
        int pick;
        logic [7:0] cur;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            len = 0;
        end else if (pick == 1) begin
            len = $urandom_range(KEY_BYTES, 255);
        end else begin
            len = $urandom_range(1, 2);
        end
        frame_bytes.delete();
        frame_bytes.push_back(8'(len));
        if (len < KEY_BYTES) begin
            for (int i = 0; i < len; i++) begin
                cur = key_map[i];
                case ($urandom_range(0, 3))
                    0: frame_bytes.push_back(cur);
                    1: frame_bytes.push_back(cur ^ (8'd1 << $urandom_range(0, 7)));
                    2: frame_bytes.push_back(8'($urandom));
                    default: frame_bytes.push_back(~cur);
                endcase
            end
        end
    endtask

    // Result side: random tready gaps, one long hold-off on request, and the
    // check of every accepted result against the oldest predicted event.
    initial begin
        int         gap;
        logic       got;
        key_event_t seen;
        key_event_t want;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = $urandom_range(0, snk_gap_max);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got          = m_tvalid;
                seen.kind    = m_tuser;
                seen.pos     = m_tdata[6:0];
                seen.pressed = m_tdata[7];
                seen.last    = m_tlast;
                @(posedge aclk);
            end while (!got);
            if (pending_events.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: expected no key event, got kind %0d pos %0d pressed %0d last %0d",
                             $time, seen.kind, seen.pos, seen.pressed, seen.last);
                end
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                if (want.kind != seen.kind || want.pos != seen.pos ||
                    want.pressed != seen.pressed || want.last != seen.last) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: key event mismatch, expected kind %0d pos %0d pressed %0d last %0d, got kind %0d pos %0d pressed %0d last %0d",
                                 $time, want.kind, want.pos, want.pressed, want.last,
                                 seen.kind, seen.pos, seen.pressed, seen.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Sample side: reset, the directed frames, a back-pressure frame, and then
    // random phases, each with its own bit period and idling pattern.
    initial begin
        frame_row_t                    row;
        int                            frames_done;
        int                            waited;
        logic [swkr_pkg::PERIOD_W-1:0] next_period;

        rx_mode      = swkr_pkg::MODE_IDLE;
        prev_level   = 1'b1;
        tick_cnt     = '0;
        bit_cnt      = '0;
        shift_reg    = '0;
        byte_idx     = '0;
        frame_len    = '0;
        bit_period   = swkr_pkg::BIT_PERIOD_RESET;
        foreach (key_map[i]) key_map[i] = '0;
        items_sent   = 0;
        mismatches   = 0;
        typed_active = 1'b0;
        rx_hold_req  = 1'b0;
        last_tight   = 1'b0;
        src_gap_max  = 0;
        snk_gap_max  = 0;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_frames[r]) begin
            row = directed_frames[r];
            if (row.period != bit_period) set_period(row.period);
            src_gap_max = ($urandom_range(0, 1) == 1) ? 12 : 0;
            snk_gap_max = ($urandom_range(0, 1) == 1) ? 12 : 0;
            if (row.typed) begin
                drain();
                typed_active = 1'b1;
                if (row.typed_one) pending_events.push_back(row.typed_ev);
            end
            if (row.nbytes == 0) begin
                repeat ($urandom_range(2, 4)) send_sample(1'b1);
                last_tight = 1'b0;
            end else begin
                frame_bytes.delete();
                for (int i = 0; i < row.nbytes; i++) frame_bytes.push_back(row.bytes[8*i +: 8]);
                run_frame(row.tight, 1'b0);
            end
            if (row.typed) begin
                pad_to_idle();
                drain();
                typed_active = 1'b0;
            end
        end

        // Five bytes with every key flipped while the output holds off for a
        // long stretch, so the byte queue fills and the sample input must stall.
        set_period(16'd1);
        src_gap_max = 0;
        snk_gap_max = 0;
        frame_bytes.delete();
        frame_bytes.push_back(8'd5);
        for (int i = 0; i < 5; i++) frame_bytes.push_back(~key_map[i]);
        rx_hold_req = 1'b1;
        run_frame(1'b0, 1'b0);
        drain();

        frames_done = 0;
        while (frames_done < 2 || items_sent < ITEM_TARGET) begin
            if (frames_done % 2 == 0) begin
                case ($urandom_range(0, 3))
                    0:       next_period = 16'd0;
                    1:       next_period = 16'd1;
                    2:       next_period = 16'd2;
                    default: next_period = 16'd3;
                endcase
                set_period(next_period);
                src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                snk_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
            case ($urandom_range(0, 9))
                0: begin
                    // Line noise: random levels in short runs.
                    repeat ($urandom_range(3, 12)) send_sample(1'($urandom_range(0, 1)));
                    last_tight = 1'b0;
                end
                1: begin
                    random_frame_bytes();
                    run_frame(1'b0, 1'b1);
                end
                default: begin
                    random_frame_bytes();
                    run_frame($urandom_range(0, 3) == 0, 1'b0);
                end
            endcase
            frames_done++;
        end

        // Wind down: let every predicted event arrive, then a short settle.
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_events.size() > 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (pending_events.size() > 0) begin
            $display("%0t: expected %0d more key events, got none", $time, pending_events.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
